/* rtl/core/tle_pkg.sv */
// Shared types, constants and helper functions of the terminal line editor.
// No dependencies; every other file of the block but tle_ram uses this package.
package tle_pkg;

   // line store geometry
   localparam int LINE_DEPTH = 32;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

   // width of the limit register
   localparam int LIMIT_W    = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(25);

   // special characters
   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_BANG  = 8'd33;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_DOT   = 8'd46;
   localparam logic [7:0] CHAR_DEL   = 8'd127;
   localparam logic [7:0] CHAR_0     = 8'd48;
   localparam logic [7:0] CHAR_9     = 8'd57;
   localparam logic [7:0] CHAR_UA    = 8'd65;
   localparam logic [7:0] CHAR_UZ    = 8'd90;
   localparam logic [7:0] CHAR_LA    = 8'd97;
   localparam logic [7:0] CHAR_LZ    = 8'd122;

   // result destinations
   localparam logic DEST_CONSOLE = 1'b0;
   localparam logic DEST_LINK    = 1'b1;

   // command kinds handed from front to back
   typedef enum logic [1:0] {
      KIND_IGNORE,
      KIND_STORE,
      KIND_ERASE,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       last;
   } rsp_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BS1,
      ST_SP,
      ST_BS2,
      ST_ECHO,
      ST_FLUSH
   } state_type;

   // byte classification
   function automatic kind_type classify(input logic [7:0] c);
      kind_type k;
      k = KIND_IGNORE;
      if (c == CHAR_CR || c == CHAR_LF) begin
         k = KIND_END;
      end else if (c == CHAR_BS || c == CHAR_DEL) begin
         k = KIND_ERASE;
      end else if ((c >= CHAR_UA && c <= CHAR_UZ) || (c >= CHAR_LA && c <= CHAR_LZ) ||
                   (c >= CHAR_0 && c <= CHAR_9) || c == CHAR_SPACE || c == CHAR_BANG ||
                   c == CHAR_DOT || c == CHAR_PLUS || c == CHAR_MINUS) begin
         k = KIND_STORE;
      end
      return k;
   endfunction

   // effective limit: zero acts as one, clipped to the store depth
   function automatic logic [CNT_W-1:0] limit(input logic [LIMIT_W-1:0] m);
      logic [CNT_W-1:0] l;
      if (m == '0) begin
         l = CNT_W'(1);
      end else if (int'(m) > LINE_DEPTH) begin
         l = CNT_W'(LINE_DEPTH);
      end else begin
         l = CNT_W'(m);
      end
      return l;
   endfunction

endpackage

/* rtl/core/terminal_line_editor_unit.sv */
// Terminal line editor: received console bytes in, echo and line bytes out.
// An ignored byte is dropped on transfer. A stored character is echoed into
// the result queue, an erase of a stored byte gives three results, and an
// ended line drains one byte per cycle from the single read port of the line
// store while the result queue has space. A two-entry command queue parts
// the classifying front end from the sequencer, and a two-entry result queue
// lets input transfers continue while results wait to be taken.
// Depends on tle_pkg, tle_front, tle_cmd_queue, tle_back and tle_ram.
module terminal_line_editor_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [7:0]                  req_rx_byte,
   output logic                        empty,
   input  logic                        pop,
   output logic                        rsp_dest,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [tle_pkg::LIMIT_W-1:0] csr_wr_data
);

   logic             cmd_push;
   logic             cmd_full;
   logic             cmd_pop;
   logic             cmd_empty;
   tle_pkg::cmd_type front_cmd;
   tle_pkg::cmd_type queue_cmd;
   tle_pkg::rsp_type rsp;

   tle_front u_front (
      .push        (push),
      .req_rx_byte (req_rx_byte),
      .full        (full),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd         (front_cmd)
   );

   tle_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_cmd  (queue_cmd),
      .empty    (cmd_empty)
   );

   tle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_empty   (cmd_empty),
      .cmd         (queue_cmd),
      .cmd_pop     (cmd_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp         (rsp)
   );

   assign rsp_dest     = rsp.dest;
   assign rsp_out_byte = rsp.data;
   assign rsp_last     = rsp.last;

endmodule

/* rtl/core/tle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tle_front.sv */
// Front end: accepts received bytes, classifies them and enqueues commands.
// Depends on tle_pkg.
module tle_front (
   input  logic             push,
   input  logic [7:0]       req_rx_byte,
   output logic             full,
   input  logic             cmd_full,
   output logic             cmd_push,
   output tle_pkg::cmd_type cmd
);

   tle_pkg::kind_type kind;

   // classify the incoming byte
   always_comb begin
      kind     = tle_pkg::classify(req_rx_byte);
      cmd.kind = kind;
      cmd.data = req_rx_byte;
   end

   // ignored bytes are taken and dropped here
   assign full     = cmd_full;
   assign cmd_push = push && !cmd_full && (kind != tle_pkg::KIND_IGNORE);

endmodule

/* rtl/core/tle_cmd_queue.sv */
// Two-entry command queue between the front and back ends.
// Depends on tle_pkg.
module tle_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tle_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output tle_pkg::cmd_type pop_cmd,
   output logic             empty
);

   tle_pkg::cmd_type entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign pop_cmd = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wptr_in = do_push ? ~wptr_ff : wptr_ff;
      rptr_in = do_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/tle_back.sv */
// Back end: carries out commands, owns the line store, count and limit,
// and buffers results in a two-entry output queue.
// Depends on tle_pkg and tle_ram.
module tle_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [tle_pkg::LIMIT_W-1:0]   csr_wr_data,
   input  logic                          cmd_empty,
   input  tle_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          empty,
   input  logic                          pop,
   output tle_pkg::rsp_type              rsp
);

   localparam int CW = tle_pkg::CNT_W;
   localparam int AW = tle_pkg::ADDR_W;

   tle_pkg::state_type state_ff, state_in;
   logic [tle_pkg::LIMIT_W-1:0] max_chars_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          final_ff, final_in;
   logic [7:0]    byte_ff, byte_in;
   logic [CW-1:0] lim;
   logic [CW-1:0] count_inc;

   // line store ports
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [7:0]    ram_rd_data;

   // output queue
   tle_pkg::rsp_type out_q_ff [2];
   logic       owptr_ff, orptr_ff;
   logic [1:0] ocnt_ff;
   logic       space;
   logic       rsp_push;
   tle_pkg::rsp_type rsp_item;
   logic       do_pop;

   assign lim       = tle_pkg::limit(max_chars_ff);
   assign count_inc = count_ff + CW'(1);
   assign space     = (ocnt_ff != 2'd2);
   assign empty     = (ocnt_ff == 2'd0);
   assign rsp       = out_q_ff[orptr_ff];
   assign do_pop    = pop && !empty;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= tle_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   tle_ram #(
      .WIDTH (8),
      .DEPTH (tle_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (byte_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // sequencer next state and outputs
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      rd_valid_in = rd_valid_ff;
      final_in    = final_ff;
      byte_in     = byte_ff;
      cmd_pop     = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      rsp_push    = 1'b0;
      rsp_item    = '{dest: tle_pkg::DEST_CONSOLE, data: tle_pkg::CHAR_BS, last: 1'b0};
      case (state_ff)
         tle_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop     = 1'b1;
               idx_in      = '0;
               rd_valid_in = 1'b0;
               case (cmd.kind)
                  tle_pkg::KIND_END: begin
                     if (count_ff != '0) begin
                        final_in = 1'b1;
                        state_in = tle_pkg::ST_FLUSH;
                     end
                  end
                  tle_pkg::KIND_ERASE: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                        state_in = tle_pkg::ST_BS1;
                     end
                  end
                  tle_pkg::KIND_STORE: begin
                     byte_in = cmd.data;
                     if (count_ff >= lim) begin
                        // line already at the limit: send it before the echo
                        final_in = 1'b0;
                        state_in = tle_pkg::ST_FLUSH;
                     end else begin
                        state_in = tle_pkg::ST_ECHO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tle_pkg::ST_BS1: begin
            if (space) begin
               rsp_push = 1'b1;
               state_in = tle_pkg::ST_SP;
            end
         end
         tle_pkg::ST_SP: begin
            rsp_item.data = tle_pkg::CHAR_SPACE;
            if (space) begin
               rsp_push = 1'b1;
               state_in = tle_pkg::ST_BS2;
            end
         end
         tle_pkg::ST_BS2: begin
            rsp_item.last = 1'b1;
            if (space) begin
               rsp_push = 1'b1;
               state_in = tle_pkg::ST_IDLE;
            end
         end
         tle_pkg::ST_ECHO: begin
            // echo, store, and end the line when the limit is reached
            rsp_item.data = byte_ff;
            rsp_item.last = (count_inc < lim);
            if (space) begin
               rsp_push  = 1'b1;
               ram_wr_en = 1'b1;
               count_in  = count_inc;
               if (count_inc >= lim) begin
                  final_in    = 1'b1;
                  idx_in      = '0;
                  rd_valid_in = 1'b0;
                  state_in    = tle_pkg::ST_FLUSH;
               end else begin
                  state_in = tle_pkg::ST_IDLE;
               end
            end
         end
         tle_pkg::ST_FLUSH: begin
            // one read in flight; a new read issues as the held byte leaves
            rsp_item.dest = tle_pkg::DEST_LINK;
            rsp_item.data = ram_rd_data;
            rsp_item.last = final_ff && (idx_ff == count_ff);
            rsp_push      = rd_valid_ff && space;
            ram_rd_en     = (idx_ff < count_ff) && (!rd_valid_ff || rsp_push);
            if (ram_rd_en) begin
               idx_in      = idx_ff + CW'(1);
               rd_valid_in = 1'b1;
            end else if (rsp_push) begin
               rd_valid_in = 1'b0;
            end
            if (rsp_push && idx_ff == count_ff) begin
               count_in = '0;
               state_in = final_ff ? tle_pkg::ST_IDLE : tle_pkg::ST_ECHO;
            end
         end
         default: begin
            state_in = tle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tle_pkg::ST_IDLE;
         count_ff    <= '0;
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         rd_valid_ff <= rd_valid_in;
         final_ff    <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // output queue bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff <= 1'b0;
         orptr_ff <= 1'b0;
         ocnt_ff  <= 2'd0;
      end else begin
         if (rsp_push) begin
            owptr_ff <= ~owptr_ff;
         end
         if (do_pop) begin
            orptr_ff <= ~orptr_ff;
         end
         ocnt_ff <= ocnt_ff + {1'b0, rsp_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         out_q_ff[owptr_ff] <= rsp_item;
      end
   end

endmodule
